// ----- hw/rtl/scap_pkg.sv -----
// ----------------------------------------------------------------------------
// Smart card ATR parser package
// Shared types, parse phase codes, byte kind codes and size constants.
// ----------------------------------------------------------------------------
package scap_pkg;

   // Byte count above which overflow is flagged; legal range is 33 to 126.
   localparam int MAX_ATR_BYTES = 64;
   localparam int COUNT_LIMIT_INT = (MAX_ATR_BYTES + 1 > 127) ? 127 : MAX_ATR_BYTES + 1;
   localparam logic [6:0] COUNT_LIMIT = 7'(COUNT_LIMIT_INT);
   localparam logic [7:0] MAX_ATR_BYTES_B = 8'(MAX_ATR_BYTES);

   localparam logic [7:0] TS_DIRECT  = 8'h3B;
   localparam logic [7:0] TS_INVERSE = 8'h3F;
   localparam logic [3:0] GROUP_MAX  = 4'd15;

   localparam logic [2:0] PH_WAIT_TS = 3'd0;
   localparam logic [2:0] PH_T0      = 3'd1;
   localparam logic [2:0] PH_IFACE   = 3'd2;
   localparam logic [2:0] PH_HIST    = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   localparam logic [3:0] KIND_IGNORED    = 4'd0;
   localparam logic [3:0] KIND_TS         = 4'd1;
   localparam logic [3:0] KIND_T0         = 4'd2;
   localparam logic [3:0] KIND_TA         = 4'd3;
   localparam logic [3:0] KIND_TB         = 4'd4;
   localparam logic [3:0] KIND_TC         = 4'd5;
   localparam logic [3:0] KIND_TD         = 4'd6;
   localparam logic [3:0] KIND_HISTORICAL = 4'd7;
   localparam logic [3:0] KIND_TRAILING   = 4'd8;

   typedef struct packed {
      logic [2:0] parse_phase;
      logic [3:0] pending_mask;
      logic [3:0] group_index;
      logic [3:0] historical_left;
      logic [3:0] historical_count;
      logic [6:0] byte_counter;
      logic [7:0] ta1_reg;
      logic       ta1_flag;
      logic [7:0] tc1_reg;
      logic       tc1_flag;
      logic [3:0] protocol_reg;
      logic       inverse_flag;
   } scap_state_type;

   localparam scap_state_type STATE_RESET = '{
      parse_phase:      PH_WAIT_TS,
      pending_mask:     4'd0,
      group_index:      4'd0,
      historical_left:  4'd0,
      historical_count: 4'd0,
      byte_counter:     7'd0,
      ta1_reg:          8'd0,
      ta1_flag:         1'b0,
      tc1_reg:          8'd0,
      tc1_flag:         1'b0,
      protocol_reg:     4'd0,
      inverse_flag:     1'b0
   };

   typedef struct packed {
      logic [3:0] byte_kind;
      logic [3:0] group_number;
      logic       inverse_convention;
      logic [3:0] historical_total;
      logic [3:0] first_protocol;
      logic       ta1_seen;
      logic [7:0] ta1_value;
      logic       tc1_seen;
      logic [7:0] tc1_value;
      logic       atr_complete;
      logic [6:0] bytes_taken;
      logic       overflow;
   } scap_rsp_type;

endpackage

// ----- hw/rtl/scap_if.sv -----
// ----------------------------------------------------------------------------
// Smart card ATR parser channels
// Valid/ready request and response channels carrying the parser payload.
// ----------------------------------------------------------------------------
interface scap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] atr_byte;
   logic       restart;

   modport source (output valid, output atr_byte, output restart, input ready);
   modport sink (input valid, input atr_byte, input restart, output ready);
endinterface

interface scap_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] byte_kind;
   logic [3:0] group_number;
   logic       inverse_convention;
   logic [3:0] historical_total;
   logic [3:0] first_protocol;
   logic       ta1_seen;
   logic [7:0] ta1_value;
   logic       tc1_seen;
   logic [7:0] tc1_value;
   logic       atr_complete;
   logic [6:0] bytes_taken;
   logic       overflow;

   modport source (
      output valid, input ready,
      output byte_kind, output group_number, output inverse_convention,
      output historical_total, output first_protocol, output ta1_seen,
      output ta1_value, output tc1_seen, output tc1_value, output atr_complete,
      output bytes_taken, output overflow
   );
   modport sink (
      input valid, output ready,
      input byte_kind, input group_number, input inverse_convention,
      input historical_total, input first_protocol, input ta1_seen,
      input ta1_value, input tc1_seen, input tc1_value, input atr_complete,
      input bytes_taken, input overflow
   );
endinterface

// ----- hw/rtl/scap_parse_core.sv -----
// ----------------------------------------------------------------------------
// Smart card ATR parser core
// Classifies one byte against the current parse state and forms the next
// state and the response for that byte.
// ----------------------------------------------------------------------------
module scap_parse_core (
   input  scap_pkg::scap_state_type cur_state,
   input  logic [7:0]               atr_byte,
   input  logic                     restart,
   output scap_pkg::scap_state_type nxt_state,
   output scap_pkg::scap_rsp_type   rsp
);
   import scap_pkg::*;

   scap_state_type st;
   scap_state_type nx;
   logic [3:0]     kind;
   logic [3:0]     grp;
   logic [3:0]     left_dec;

   function automatic logic [2:0] after_interface(input logic [3:0] mask,
                                                  input logic [3:0] left);
      if (mask != 4'd0) begin
         return PH_IFACE;
      end else if (left != 4'd0) begin
         return PH_HIST;
      end
      return PH_DONE;
   endfunction

   always_comb begin
      st       = restart ? STATE_RESET : cur_state;
      nx       = st;
      kind     = KIND_IGNORED;
      grp      = 4'd0;
      left_dec = (st.historical_left != 4'd0) ? st.historical_left - 4'd1 : 4'd0;

      unique case (st.parse_phase)
         PH_WAIT_TS: begin
            if (atr_byte == TS_DIRECT || atr_byte == TS_INVERSE) begin
               kind            = KIND_TS;
               nx.inverse_flag = (atr_byte == TS_INVERSE);
               nx.parse_phase  = PH_T0;
            end
         end
         PH_T0: begin
            kind                = KIND_T0;
            nx.historical_count = atr_byte[3:0];
            nx.historical_left  = atr_byte[3:0];
            nx.pending_mask     = atr_byte[7:4];
            nx.group_index      = 4'd1;
            nx.parse_phase      = after_interface(atr_byte[7:4], atr_byte[3:0]);
         end
         PH_IFACE: begin
            grp = st.group_index;
            if (st.pending_mask[0]) begin
               kind            = KIND_TA;
               nx.pending_mask = st.pending_mask & 4'b1110;
               if (st.group_index == 4'd1) begin
                  nx.ta1_reg  = atr_byte;
                  nx.ta1_flag = 1'b1;
               end
            end else if (st.pending_mask[1]) begin
               kind            = KIND_TB;
               nx.pending_mask = st.pending_mask & 4'b1100;
            end else if (st.pending_mask[2]) begin
               kind            = KIND_TC;
               nx.pending_mask = st.pending_mask & 4'b1000;
               if (st.group_index == 4'd1) begin
                  nx.tc1_reg  = atr_byte;
                  nx.tc1_flag = 1'b1;
               end
            end else begin
               kind            = KIND_TD;
               nx.pending_mask = atr_byte[7:4];
               if (st.group_index == 4'd1) begin
                  nx.protocol_reg = atr_byte[3:0];
               end
               if (st.group_index != GROUP_MAX) begin
                  nx.group_index = st.group_index + 4'd1;
               end
            end
            nx.parse_phase = after_interface(nx.pending_mask, st.historical_left);
         end
         PH_HIST: begin
            kind               = KIND_HISTORICAL;
            nx.historical_left = left_dec;
            if (left_dec == 4'd0) begin
               nx.parse_phase = PH_DONE;
            end
         end
         default: begin
            kind           = KIND_TRAILING;
            nx.parse_phase = PH_DONE;
         end
      endcase

      if (kind != KIND_IGNORED && st.byte_counter < COUNT_LIMIT) begin
         nx.byte_counter = st.byte_counter + 7'd1;
      end
   end

   assign nxt_state = nx;

   always_comb begin
      rsp.byte_kind          = kind;
      rsp.group_number       = grp;
      rsp.inverse_convention = nx.inverse_flag;
      rsp.historical_total   = nx.historical_count;
      rsp.first_protocol     = nx.protocol_reg;
      rsp.ta1_seen           = nx.ta1_flag;
      rsp.ta1_value          = nx.ta1_reg;
      rsp.tc1_seen           = nx.tc1_flag;
      rsp.tc1_value          = nx.tc1_reg;
      rsp.atr_complete       = (nx.parse_phase == PH_DONE);
      rsp.bytes_taken        = nx.byte_counter;
      rsp.overflow           = ({1'b0, nx.byte_counter} > MAX_ATR_BYTES_B);
   end

endmodule

// ----- hw/rtl/smart_card_atr_parser_top.sv -----
// ----------------------------------------------------------------------------
// Smart card ATR parser top level
// Path: a request is held in the input register, then the parse logic writes
// its result into the response register once the response stage is free.
// Throughput: one request per cycle while responses are taken; the single
// parse state update per byte is the loop that sets this rate.
// Reset: synchronous, clears the parse state and the valid flags of both stages.
// ----------------------------------------------------------------------------
module smart_card_atr_parser_top (
   input logic         clock,
   input logic         reset,
   scap_req_if.sink    req,
   scap_rsp_if.source  rsp
);
   import scap_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_restart_ff;
   logic           rsp_valid_ff;
   logic           advance;
   scap_state_type state_ff;
   scap_state_type state_in;
   scap_rsp_type   rsp_ff;
   scap_rsp_type   rsp_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   scap_parse_core u_core (
      .cur_state (state_ff),
      .atr_byte  (in_byte_ff),
      .restart   (in_restart_ff),
      .nxt_state (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff    <= req.atr_byte;
         in_restart_ff <= req.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.byte_kind          = rsp_ff.byte_kind;
   assign rsp.group_number       = rsp_ff.group_number;
   assign rsp.inverse_convention = rsp_ff.inverse_convention;
   assign rsp.historical_total   = rsp_ff.historical_total;
   assign rsp.first_protocol     = rsp_ff.first_protocol;
   assign rsp.ta1_seen           = rsp_ff.ta1_seen;
   assign rsp.ta1_value          = rsp_ff.ta1_value;
   assign rsp.tc1_seen           = rsp_ff.tc1_seen;
   assign rsp.tc1_value          = rsp_ff.tc1_value;
   assign rsp.atr_complete       = rsp_ff.atr_complete;
   assign rsp.bytes_taken        = rsp_ff.bytes_taken;
   assign rsp.overflow           = rsp_ff.overflow;

`ifndef SYNTHESIS
   a_pending_only_in_iface: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_mask != 4'd0 |-> state_ff.parse_phase == PH_IFACE)
      else $error("interface bytes pending outside the interface phase");

   a_hist_left_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.historical_left != 4'd0 |->
         (state_ff.parse_phase == PH_IFACE || state_ff.parse_phase == PH_HIST))
      else $error("historical bytes left after parsing ended");

   a_counter_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_counter <= COUNT_LIMIT)
      else $error("byte counter passed its saturation limit");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled request lost from the input register");
`endif

endmodule
